// ===== hw/rtl/bps_pkg.sv =====
// bps_pkg: shared types and constants for the byte pattern search block
// item payloads for both channels, cell control and configuration register indexes
// no dependencies
package bps_pkg;

  localparam int unsigned PAT_BYTES = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LEN_W = 6;
  localparam int unsigned OFFSET_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_0_7   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_8_15  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_16_23 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_24_31 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 3'd4;

  typedef struct packed {
    logic [7:0]          text_byte;
    logic                first_item;
    logic                last_item;
    logic                carries_no_byte;
    logic [OFFSET_W-1:0] start_from;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] match_index;
  } out_item_t;

  // window cell load control: one copy drives the head cell, another is shared by the other cells
  typedef struct packed {
    logic load;
    logic zero;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/bps_if.sv =====
// bps_if: valid/ready stream interfaces for the input and result channels
// depends on bps_pkg for the item payload types
interface bps_in_if;
  logic             valid;
  logic             ready;
  bps_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface bps_out_if;
  logic               valid;
  logic               ready;
  bps_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== hw/rtl/bps_cell.sv =====
// bps_cell: one position of the text window with its aligned pattern byte
// depends on bps_pkg for the cell control struct
module bps_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  bps_pkg::cell_ctl_t ctl,
  input  logic [7:0]         d_in,
  input  logic [7:0]         ref_in,
  input  logic               skip_in,
  output logic [7:0]         win,
  output logic               eq
);

  logic [7:0] win_r;
  logic [7:0] win_nxt;
  logic [7:0] ref_r;
  logic       skip_r;

  always_comb begin
    win_nxt = win_r;
    if (ctl.load) begin
      win_nxt = ctl.zero ? 8'd0 : d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else begin
      win_r <= win_nxt;
    end
    ref_r  <= ref_in;
    skip_r <= skip_in;
  end

  // positions beyond the pattern length always agree
  assign eq  = skip_r | (win_r == ref_r);
  assign win = win_r;

endmodule

// ===== hw/rtl/byte_pattern_search.sv =====
// byte_pattern_search: streamed search for a configured byte pattern of up to 32 bytes
// depends on bps_pkg, bps_if (bps_in_if, bps_out_if) and bps_cell
//
// Usage: load the pattern bytes and the pattern length through cfg_we / cfg_index /
// cfg_data while no search is in flight. Text bytes then stream in on in_ch, one per
// item; first_item opens a search and samples start_from, last_item closes the text,
// and carries_no_byte marks an item without a byte (empty text). Each search gives
// exactly one item on out_ch: the index of the leftmost match at or after the start
// offset as soon as its last byte arrives, or not-found with the last item.
// Items between the result and the next first_item give nothing.
// A result passes the compare stage and then the output register once its item is
// accepted. Throughput: one item per cycle while in_ch is ready; a row of MAX_PATTERN
// window cells shifts once per item and all cells compare in the cycle after acceptance.
// Reset (synchronous, rst_n low) clears the pattern registers, the window, the count,
// the start offset and the pipeline. When out_ch stalls, the result waits in the
// output register and items keep flowing as long as the item in the compare stage
// gives no result; once that item has a result of its own, in_ch.ready drops until
// out_ch takes the waiting one.
module byte_pattern_search #(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned INDEX_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bps_pkg::CFG_DATA_W-1:0]    cfg_data,
  bps_in_if.sink                            in_ch,
  bps_out_if.source                         out_ch
);

  localparam int unsigned CNT_W = INDEX_BITS + 1;
  localparam int unsigned CMP_W = (CNT_W > bps_pkg::OFFSET_W) ? CNT_W
                                                              : bps_pkg::OFFSET_W + 1;
  localparam logic [CNT_W-1:0] COUNT_CAP = {CNT_W{1'b1}};
  localparam logic [CMP_W-1:0] MAX_INDEX = CMP_W'(COUNT_CAP >> 1);

  // configuration
  logic [bps_pkg::CFG_DATA_W-1:0] pat_r [4];
  logic [bps_pkg::LEN_W-1:0]      len_r;
  logic [8*bps_pkg::PAT_BYTES-1:0] pat_all;
  logic [bps_pkg::LEN_W-1:0]      len_use;

  // search state
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [bps_pkg::OFFSET_W-1:0] start_r, start_nxt;
  logic                         given_r, given_nxt;

  // compare stage
  logic                         s1_valid_r, s1_valid_nxt;
  logic                         s1_first_r, s1_last_r, s1_cand_r, s1_empty_r;
  logic [bps_pkg::OFFSET_W-1:0] s1_index_r;

  // output register
  logic               out_valid_r, out_valid_nxt;
  bps_pkg::out_item_t out_item_r;

  // cell row
  logic [7:0]             win [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq_vec;
  bps_pkg::cell_ctl_t     ctl_head, ctl_body;

  logic                   accept, present, sat;
  logic [CNT_W-1:0]       count_base;
  logic [CMP_W-1:0]       count_x, start_x, len_x, s_x;
  logic                   cand, is_empty;
  logic [bps_pkg::OFFSET_W-1:0] index_c;
  logic                   given_eff, hit, s1_emit, s1_adv, out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        pat_r[i] <= '0;
      end
      len_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bps_pkg::REG_PAT_0_7:   pat_r[0] <= cfg_data;
        bps_pkg::REG_PAT_8_15:  pat_r[1] <= cfg_data;
        bps_pkg::REG_PAT_16_23: pat_r[2] <= cfg_data;
        bps_pkg::REG_PAT_24_31: pat_r[3] <= cfg_data;
        bps_pkg::REG_PAT_LEN:   len_r    <= cfg_data[bps_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_all = {pat_r[3], pat_r[2], pat_r[1], pat_r[0]};
  assign len_use = (len_r > bps_pkg::LEN_W'(MAX_PATTERN)) ? bps_pkg::LEN_W'(MAX_PATTERN)
                                                          : len_r;

  // handshake
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_adv   = !s1_valid_r || !s1_emit || out_free;
  assign in_ch.ready = s1_adv;
  assign accept   = in_ch.valid && s1_adv;

  // window cell row: cell k holds the byte k positions before the newest one
  assign present       = !in_ch.item.carries_no_byte;
  assign ctl_head.load = accept && (in_ch.item.first_item || present);
  assign ctl_head.zero = !present;
  assign ctl_body.load = ctl_head.load;
  assign ctl_body.zero = !present || in_ch.item.first_item;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [bps_pkg::LEN_W-1:0] ref_idx;
    logic                      skip;

    // cell k faces pattern byte len-1-k
    assign ref_idx = len_use - bps_pkg::LEN_W'(1) - bps_pkg::LEN_W'(k);
    assign skip    = bps_pkg::LEN_W'(k) >= len_use;

    if (k == 0) begin : g_head
      bps_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_head),
        .d_in    (in_ch.item.text_byte),
        .ref_in  (pat_all[{ref_idx[4:0], 3'b000} +: 8]),
        .skip_in (skip),
        .win     (win[k]),
        .eq      (eq_vec[k])
      );
    end else begin : g_body
      bps_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_body),
        .d_in    (win[k-1]),
        .ref_in  (pat_all[{ref_idx[4:0], 3'b000} +: 8]),
        .skip_in (skip),
        .win     (win[k]),
        .eq      (eq_vec[k])
      );
    end
  end

  // count, start offset and match eligibility for the item being accepted
  always_comb begin
    count_base = in_ch.item.first_item ? '0 : count_r;
    sat        = present && (count_base == COUNT_CAP);
    count_nxt  = count_r;
    start_nxt  = start_r;
    if (accept) begin
      count_nxt = (present && !sat) ? count_base + CNT_W'(1) : count_base;
      start_nxt = in_ch.item.first_item ? in_ch.item.start_from : start_r;
    end
  end

  always_comb begin
    count_x  = CMP_W'(count_nxt);
    start_x  = CMP_W'(start_nxt);
    len_x    = CMP_W'(len_use);
    s_x      = count_x - len_x;
    is_empty = (len_use == '0);
    if (is_empty) begin
      cand    = (start_x <= count_x) && (start_x <= MAX_INDEX);
      index_c = start_nxt;
    end else begin
      cand    = present && !sat && (count_x >= len_x) && (s_x >= start_x)
                && (s_x <= MAX_INDEX);
      index_c = s_x[bps_pkg::OFFSET_W-1:0];
    end
  end

  // compare stage decision
  assign given_eff = s1_first_r ? 1'b0 : given_r;
  assign hit       = s1_cand_r && (s1_empty_r || (&eq_vec));
  assign s1_emit   = !given_eff && (hit || s1_last_r);

  always_comb begin
    given_nxt = given_r;
    if (s1_valid_r && s1_adv) begin
      given_nxt = given_eff || s1_emit;
    end
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_valid_r && s1_emit && s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      start_r     <= '0;
      given_r     <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      start_r     <= start_nxt;
      given_r     <= given_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_first_r <= in_ch.item.first_item;
      s1_last_r  <= in_ch.item.last_item;
      s1_cand_r  <= cand;
      s1_empty_r <= is_empty;
      s1_index_r <= index_c;
    end
    if (s1_valid_r && s1_emit && s1_adv) begin
      out_item_r.found       <= hit;
      out_item_r.match_index <= hit ? s1_index_r : '0;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.item  = out_item_r;

endmodule
